/* hdl/sbf_pkg.sv */
`default_nettype none
package sbf_pkg;

  // Frame geometry
  localparam int BLOCK_BYTES = 32;
  localparam int HIGH_BYTES  = (BLOCK_BYTES + 6) / 7;
  localparam int HB_W        = HIGH_BYTES * 7;
  localparam int HDR_BYTES   = 5;
  localparam int FILL_W      = $clog2(BLOCK_BYTES + 1);
  localparam int CNT_W       = $clog2(BLOCK_BYTES + HIGH_BYTES);
  localparam int SEQ_W       = 7;
  localparam int DEV_W       = 7;

  // Sysex framing bytes
  localparam logic [7:0] SYX_START = 8'hF0;
  localparam logic [7:0] SYX_MFR0  = 8'h00;
  localparam logic [7:0] SYX_MFR1  = 8'h7F;
  localparam logic [7:0] SYX_EOX   = 8'hF7;
  localparam logic [7:0] SYX_ZERO  = 8'h00;
  localparam logic [6:0] PAD_LOW   = 7'h7F;

  // Sequence number range
  localparam logic [SEQ_W-1:0] SEQ_FIRST = 7'd1;
  localparam logic [SEQ_W-1:0] SEQ_LAST  = 7'd127;
  localparam logic [SEQ_W-1:0] SEQ_TERM  = 7'd0;

  // Input function codes
  localparam logic [1:0] FUNC_DATA  = 2'd0;
  localparam logic [1:0] FUNC_CLOSE = 2'd1;
  localparam logic [1:0] FUNC_END   = 2'd2;

  // Command queue between front and back
  localparam int Q_DEPTH = 2;
  localparam int Q_PTR_W = $clog2(Q_DEPTH);
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

  typedef enum logic [1:0] {
    CMD_DATA,
    CMD_CLOSE,
    CMD_END
  } cmd_e;

  typedef struct packed {
    cmd_e       kind;
    logic [7:0] data;
  } cmd_t;

endpackage
`default_nettype wire

/* hdl/sbf_in_if.sv */
`default_nettype none
interface sbf_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] func;
  logic [7:0] data_byte;

  modport source (output valid, output func, output data_byte, input ready);
  modport sink (input valid, input func, input data_byte, output ready);
endinterface
`default_nettype wire

/* hdl/sbf_out_if.sv */
`default_nettype none
interface sbf_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       last;

  modport source (output valid, output out_byte, output last, input ready);
  modport sink (input valid, input out_byte, input last, output ready);
endinterface
`default_nettype wire

/* hdl/sbf_cfg_if.sv */
`default_nettype none
interface sbf_cfg_if;
  logic                     valid;
  logic                     ready;
  logic [sbf_pkg::DEV_W-1:0] device_id;

  modport source (output valid, output device_id, input ready);
  modport sink (input valid, input device_id, output ready);
endinterface
`default_nettype wire

/* hdl/sbf_front.sv */
`default_nettype none
module sbf_front (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  sbf_in_if.sink              in_i,
  input  wire logic           pop_i,
  output sbf_pkg::cmd_t       head_o,
  output logic                head_valid_o
);

  sbf_pkg::cmd_t                   mem_q [sbf_pkg::Q_DEPTH];
  logic [sbf_pkg::Q_PTR_W-1:0]     wr_ptr_q, rd_ptr_q;
  logic [sbf_pkg::Q_CNT_W-1:0]     cnt_q;
  logic                            push;
  sbf_pkg::cmd_t                   cmd;

  // Classify the incoming word; unused function codes are dropped here
  always_comb begin
    cmd.data = in_i.data_byte;
    cmd.kind = sbf_pkg::CMD_DATA;
    push     = 1'b0;
    case (in_i.func)
      sbf_pkg::FUNC_DATA: begin
        cmd.kind = sbf_pkg::CMD_DATA;
        push     = 1'b1;
      end
      sbf_pkg::FUNC_CLOSE: begin
        cmd.kind = sbf_pkg::CMD_CLOSE;
        push     = 1'b1;
      end
      sbf_pkg::FUNC_END: begin
        cmd.kind = sbf_pkg::CMD_END;
        push     = 1'b1;
      end
      default: push = 1'b0;
    endcase
    push = push && in_i.valid && in_i.ready;
  end

  assign in_i.ready   = (cnt_q != sbf_pkg::Q_CNT_W'(sbf_pkg::Q_DEPTH));
  assign head_valid_o = (cnt_q != '0);
  assign head_o       = mem_q[rd_ptr_q];

  // Store commands
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= cmd;
    end
  end

  // Advance pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      if (push && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

/* hdl/sbf_back.sv */
`default_nettype none
module sbf_back (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire sbf_pkg::cmd_t             head_i,
  input  wire logic                      head_valid_i,
  input  wire logic [sbf_pkg::DEV_W-1:0] dev_id_i,
  output logic                           pop_o,
  sbf_out_if.source                      out_o
);

  localparam logic [2:0] P_IDLE = 3'd0;
  localparam logic [2:0] P_HDR  = 3'd1;
  localparam logic [2:0] P_DATA = 3'd2;
  localparam logic [2:0] P_PAD  = 3'd3;
  localparam logic [2:0] P_HIGH = 3'd4;
  localparam logic [2:0] P_ZERO = 3'd5;
  localparam logic [2:0] P_CSUM = 3'd6;
  localparam logic [2:0] P_EOX  = 3'd7;

  localparam logic [sbf_pkg::CNT_W-1:0] HDR_LAST  =
    sbf_pkg::CNT_W'(sbf_pkg::HDR_BYTES - 1);
  localparam logic [sbf_pkg::CNT_W-1:0] HIGH_LAST =
    sbf_pkg::CNT_W'(sbf_pkg::HIGH_BYTES - 1);
  localparam logic [sbf_pkg::CNT_W-1:0] ZERO_LAST =
    sbf_pkg::CNT_W'(sbf_pkg::BLOCK_BYTES + sbf_pkg::HIGH_BYTES - 1);
  localparam logic [sbf_pkg::FILL_W-1:0] FILL_LAST =
    sbf_pkg::FILL_W'(sbf_pkg::BLOCK_BYTES - 1);

  logic [2:0]                    phase_q, phase_d, ph;
  logic [sbf_pkg::CNT_W-1:0]     cnt_q, cnt_d;
  logic                          end_q, end_d, eff_end;
  logic [sbf_pkg::FILL_W-1:0]    fill_q, fill_d;
  logic [sbf_pkg::SEQ_W-1:0]     seq_q, seq_d;
  logic [6:0]                    csum_q, csum_d;
  logic [sbf_pkg::HB_W-1:0]      hb_q, hb_d;
  logic                          ovld_q, ovld_d, olast_q, olast_d;
  logic [7:0]                    obyte_q, obyte_d;
  logic                          adv, emit, last_v;
  logic [7:0]                    byte_v;
  logic [sbf_pkg::SEQ_W-1:0]     hdr_seq;

  assign out_o.valid    = ovld_q;
  assign out_o.out_byte = obyte_q;
  assign out_o.last     = olast_q;

  always_comb begin
    adv     = !ovld_q || out_o.ready;
    phase_d = phase_q;
    cnt_d   = cnt_q;
    end_d   = end_q;
    fill_d  = fill_q;
    seq_d   = seq_q;
    csum_d  = csum_q;
    hb_d    = hb_q;
    ovld_d  = ovld_q && !out_o.ready;
    obyte_d = obyte_q;
    olast_d = olast_q;
    pop_o   = 1'b0;
    emit    = 1'b0;
    last_v  = 1'b0;
    byte_v  = sbf_pkg::SYX_ZERO;
    ph      = phase_q;
    eff_end = end_q;

    // Pick the first step of a new command from the queue head
    if (phase_q == P_IDLE) begin
      eff_end = 1'b0;
      ph      = P_IDLE;
      if (head_valid_i) begin
        case (head_i.kind)
          sbf_pkg::CMD_DATA:  ph = (fill_q == '0) ? P_HDR : P_DATA;
          sbf_pkg::CMD_CLOSE: begin
            if (fill_q == '0) begin
              pop_o = 1'b1;   // nothing open: drop silently
            end else begin
              ph = P_PAD;
            end
          end
          sbf_pkg::CMD_END: begin
            ph      = P_HDR;
            eff_end = 1'b1;
          end
          default: pop_o = 1'b1;
        endcase
      end
    end

    hdr_seq = eff_end ? sbf_pkg::SEQ_TERM : seq_q;

    // Produce one stream byte per step
    if (adv) begin
      case (ph)
        P_HDR: begin
          emit  = 1'b1;
          end_d = eff_end;
          case (cnt_q)
            sbf_pkg::CNT_W'(0): byte_v = sbf_pkg::SYX_START;
            sbf_pkg::CNT_W'(1): byte_v = sbf_pkg::SYX_MFR0;
            sbf_pkg::CNT_W'(2): byte_v = sbf_pkg::SYX_MFR1;
            sbf_pkg::CNT_W'(3): byte_v = {1'b0, dev_id_i};
            default:            byte_v = {1'b0, hdr_seq};
          endcase
          if (cnt_q == HDR_LAST) begin
            csum_d  = hdr_seq;
            hb_d    = '0;
            fill_d  = '0;
            cnt_d   = '0;
            phase_d = eff_end ? P_ZERO : P_DATA;
          end else begin
            cnt_d   = cnt_q + 1'b1;
            phase_d = P_HDR;
          end
        end
        P_DATA, P_PAD: begin
          emit = 1'b1;
          hb_d = hb_q >> 1;
          if (ph == P_DATA) begin
            byte_v                        = {1'b0, head_i.data[6:0]};
            hb_d[sbf_pkg::BLOCK_BYTES-1]  = head_i.data[7];
          end else begin
            byte_v                        = {1'b0, sbf_pkg::PAD_LOW};
            hb_d[sbf_pkg::BLOCK_BYTES-1]  = 1'b1;
          end
          csum_d = csum_q ^ byte_v[6:0];
          fill_d = fill_q + 1'b1;
          if (fill_q == FILL_LAST) begin
            cnt_d   = '0;
            phase_d = P_HIGH;
          end else if (ph == P_DATA) begin
            last_v  = 1'b1;
            pop_o   = 1'b1;
            phase_d = P_IDLE;
          end else begin
            phase_d = P_PAD;
          end
        end
        P_HIGH: begin
          emit   = 1'b1;
          byte_v = {1'b0, hb_q[6:0]};
          csum_d = csum_q ^ hb_q[6:0];
          hb_d   = hb_q >> 7;
          if (cnt_q == HIGH_LAST) begin
            cnt_d   = '0;
            phase_d = P_CSUM;
          end else begin
            cnt_d = cnt_q + 1'b1;
          end
        end
        P_ZERO: begin
          emit   = 1'b1;
          byte_v = sbf_pkg::SYX_ZERO;
          if (cnt_q == ZERO_LAST) begin
            cnt_d   = '0;
            phase_d = P_CSUM;
          end else begin
            cnt_d = cnt_q + 1'b1;
          end
        end
        P_CSUM: begin
          emit    = 1'b1;
          byte_v  = {1'b0, csum_q};
          phase_d = P_EOX;
        end
        P_EOX: begin
          emit    = 1'b1;
          byte_v  = sbf_pkg::SYX_EOX;
          last_v  = 1'b1;
          pop_o   = 1'b1;
          phase_d = P_IDLE;
          fill_d  = '0;
          csum_d  = '0;
          hb_d    = '0;
          end_d   = 1'b0;
          if (end_q || seq_q == sbf_pkg::SEQ_LAST) begin
            seq_d = sbf_pkg::SEQ_FIRST;
          end else begin
            seq_d = seq_q + 1'b1;
          end
        end
        default: emit = 1'b0;
      endcase
    end

    // Load the output register
    if (emit) begin
      ovld_d  = 1'b1;
      obyte_d = byte_v;
      olast_d = last_v;
    end
  end

  // Hold frame state and the output byte
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= P_IDLE;
      cnt_q   <= '0;
      end_q   <= 1'b0;
      fill_q  <= '0;
      seq_q   <= sbf_pkg::SEQ_FIRST;
      csum_q  <= '0;
      hb_q    <= '0;
      ovld_q  <= 1'b0;
    end else begin
      phase_q <= phase_d;
      cnt_q   <= cnt_d;
      end_q   <= end_d;
      fill_q  <= fill_d;
      seq_q   <= seq_d;
      csum_q  <= csum_d;
      hb_q    <= hb_d;
      ovld_q  <= ovld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    obyte_q <= obyte_d;
    olast_q <= olast_d;
  end

endmodule
`default_nettype wire

/* hdl/sysex_block_framer_7bit_top.sv */
// Channel   Dir  Payload                 Handshake
// in_i      in   func[1:0], data_byte[7:0] valid/ready
// out_o     out  out_byte[7:0], last     valid/ready
// cfg_i     in   device_id[6:0]          valid/ready (always ready)
//
// The output register sends one byte per cycle unless out_o.ready stalls it:
// a word in an open block is one byte; a block's first word adds the header;
// a filling word adds high bytes, checksum and EOX; END sends a zero frame.
// A two-entry command queue lets the input side keep taking words while the
// framer stalls on out_o.ready. Reset is immediate: no clearing pass.
`default_nettype none
module sysex_block_framer_7bit_top (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  sbf_in_if.sink    in_i,
  sbf_out_if.source out_o,
  sbf_cfg_if.sink   cfg_i
);

  logic [sbf_pkg::DEV_W-1:0] dev_q;
  sbf_pkg::cmd_t             head;
  logic                      head_valid;
  logic                      pop;

  // Capture the device id
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dev_q <= '0;
    end else if (cfg_i.valid) begin
      dev_q <= cfg_i.device_id;
    end
  end

  sbf_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_i         (in_i),
    .pop_i        (pop),
    .head_o       (head),
    .head_valid_o (head_valid)
  );

  sbf_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_i       (head),
    .head_valid_i (head_valid),
    .dev_id_i     (dev_q),
    .pop_o        (pop),
    .out_o        (out_o)
  );

endmodule
`default_nettype wire
